// File: rtl/core/stream_substring_replace_assert.svh
// assertion macros for the stream substring replace block
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef STREAM_SUBSTRING_REPLACE_ASSERT_SVH
`define STREAM_SUBSTRING_REPLACE_ASSERT_SVH

`ifndef ASSERT_OFF
`define SSR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SSR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SSR_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SSR_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// File: rtl/core/ssr_pkg.sv
// shared types, constants and helpers of the stream substring replace block
// no dependencies
package ssr_pkg;

  localparam int MAX_PATTERN = 8;
  localparam int MAX_REPLACE = 8;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACE_LEN   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPLACE_BYTES = 2'd3;

  // one queued emission: up to eight bytes, then optionally the end of text
  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  count;
    logic        last;
    logic [31:0] match_cnt;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

// File: rtl/core/stream_substring_replace.sv
// top level of the streaming find and replace block
// depends on ssr_pkg, ssr_front, ssr_queue, ssr_back and the assertion header
//
// Replaces every leftmost, non-overlapping occurrence of a pattern of 1 to 8
// bytes in a byte stream by a replacement of 0 to 8 bytes. One text byte is
// taken per cycle; each byte with output becomes a command for a four-entry
// queue, and the output side drains one byte per cycle unless out_ready is
// low, so a byte that causes n output bytes holds the output until all are
// sent, and input keeps flowing until the queue fills. Output is registered.
// The byte flagged end_of_text flushes the window and carries out_last; when
// it causes no byte, a marker with byte_valid low is sent. Write configuration
// only while the block is empty; a pattern length write drops the window.
`include "stream_substring_replace_assert.svh"

module stream_substring_replace (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [ssr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ssr_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    text_byte,
  input  logic                          end_of_text,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_byte,
  output logic                          byte_valid,
  output logic                          out_last,
  output logic [31:0]                   out_length,
  output logic [31:0]                   match_count
);

  ssr_pkg::cmd_t          push_cmd;
  ssr_pkg::cmd_t          head_cmd;
  ssr_pkg::queue_status_t qstat;
  logic                   push;
  logic                   pop;

  ssr_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .qstat       (qstat),
    .push        (push),
    .cmd         (push_cmd)
  );

  ssr_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .cmd_in  (push_cmd),
    .pop     (pop),
    .cmd_out (head_cmd),
    .qstat   (qstat)
  );

  ssr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head_cmd),
    .qstat        (qstat),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .byte_valid   (byte_valid),
    .out_last     (out_last),
    .out_length   (out_length),
    .match_count  (match_count)
  );

  `SSR_ASSERT_IMP(a_marker_is_last, clk, rst, out_valid && !byte_valid, out_last)
  `SSR_ASSERT_IMP(a_length_counts_byte, clk, rst, out_valid && byte_valid, out_length != 32'd0)
  `SSR_ASSERT_NEXT(a_end_queued, clk, rst, in_valid && in_ready && end_of_text, !qstat.empty)

endmodule

// File: rtl/core/ssr_front.sv
// front end: configuration registers, match window and command builder
// depends on ssr_pkg
module ssr_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [ssr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ssr_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    text_byte,
  input  logic                          end_of_text,
  input  ssr_pkg::queue_status_t        qstat,
  output logic                          push,
  output ssr_pkg::cmd_t                 cmd
);

  logic [3:0]  pattern_len;
  logic [63:0] pattern_bytes;
  logic [3:0]  replace_len;
  logic [63:0] replace_bytes;

  logic [7:0]  window [ssr_pkg::MAX_PATTERN];
  logic [2:0]  fill;
  logic [31:0] matches_seen;

  logic [7:0]  w_ins [ssr_pkg::MAX_PATTERN];
  logic [3:0]  fill_ins;
  logic [3:0]  plen;
  logic [3:0]  rlen;
  logic        full;
  logic        hit;
  logic        accept;
  logic [31:0] matches_next;
  logic [2:0]  fill_next;

  assign in_ready = !qstat.full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    plen = pattern_len;
    if (pattern_len == 4'd0) plen = 4'd1;
    else if (pattern_len > 4'(ssr_pkg::MAX_PATTERN)) plen = 4'(ssr_pkg::MAX_PATTERN);
    rlen = replace_len;
    if (replace_len > 4'(ssr_pkg::MAX_REPLACE)) rlen = 4'(ssr_pkg::MAX_REPLACE);
  end

  always_comb begin
    w_ins = window;
    w_ins[fill] = text_byte;
    fill_ins = {1'b0, fill} + 4'd1;
    full = (fill_ins == plen);
    hit = full && (pattern_len != 4'd0);
    for (int i = 0; i < ssr_pkg::MAX_PATTERN; i++) begin
      if ((4'(i) < plen) && (w_ins[i] != pattern_bytes[8*i +: 8])) hit = 1'b0;
    end
    matches_next = hit ? ssr_pkg::sat_inc(matches_seen) : matches_seen;
    if (hit || end_of_text) fill_next = 3'd0;
    else if (full) fill_next = 3'(plen - 4'd1);
    else fill_next = fill_ins[2:0];
  end

  always_comb begin
    for (int i = 0; i < ssr_pkg::MAX_PATTERN; i++) begin
      cmd.data[8*i +: 8] = w_ins[i];
    end
    if (hit) begin
      cmd.data  = replace_bytes;
      cmd.count = rlen;
    end else if (full) begin
      cmd.count = end_of_text ? plen : 4'd1;
    end else begin
      cmd.count = end_of_text ? fill_ins : 4'd0;
    end
    cmd.last      = end_of_text;
    cmd.match_cnt = matches_next;
    push = accept && ((cmd.count != 4'd0) || end_of_text);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_len   <= 4'd1;
      pattern_bytes <= '0;
      replace_len   <= 4'd0;
      replace_bytes <= '0;
      fill          <= 3'd0;
      matches_seen  <= 32'd0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ssr_pkg::REG_PATTERN_LEN: begin
          pattern_len <= cfg_data[3:0];
          fill        <= 3'd0;
        end
        ssr_pkg::REG_PATTERN_BYTES: pattern_bytes <= cfg_data;
        ssr_pkg::REG_REPLACE_LEN:   replace_len   <= cfg_data[3:0];
        ssr_pkg::REG_REPLACE_BYTES: replace_bytes <= cfg_data;
        default: ;
      endcase
    end else if (accept) begin
      fill         <= fill_next;
      matches_seen <= end_of_text ? 32'd0 : matches_next;
    end
  end

  // window shifts left on a full mismatch, otherwise takes the new byte
  always_ff @(posedge clk) begin
    if (accept) begin
      if (full && !hit) begin
        for (int i = 0; i < ssr_pkg::MAX_PATTERN - 1; i++) begin
          window[i] <= w_ins[i+1];
        end
        window[ssr_pkg::MAX_PATTERN-1] <= w_ins[ssr_pkg::MAX_PATTERN-1];
      end else begin
        window <= w_ins;
      end
    end
  end

endmodule

// File: rtl/core/ssr_queue.sv
// command queue between front and back ends
// depends on ssr_pkg
module ssr_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  ssr_pkg::cmd_t          cmd_in,
  input  logic                   pop,
  output ssr_pkg::cmd_t          cmd_out,
  output ssr_pkg::queue_status_t qstat
);

  ssr_pkg::cmd_t                entries [ssr_pkg::QUEUE_DEPTH];
  logic [ssr_pkg::QPTR_W-1:0]   wr_ptr;
  logic [ssr_pkg::QPTR_W-1:0]   rd_ptr;
  logic [ssr_pkg::QCNT_W-1:0]   cnt;
  logic                         do_push;
  logic                         do_pop;

  assign qstat.full  = (cnt == ssr_pkg::QCNT_W'(ssr_pkg::QUEUE_DEPTH));
  assign qstat.empty = (cnt == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign cmd_out     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + ssr_pkg::QPTR_W'(1);
      if (do_pop) rd_ptr <= rd_ptr + ssr_pkg::QPTR_W'(1);
      cnt <= cnt + ssr_pkg::QCNT_W'(do_push) - ssr_pkg::QCNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= cmd_in;
  end

endmodule

// File: rtl/core/ssr_back.sv
// back end: expands queued commands into output bytes and keeps the length count
// depends on ssr_pkg
module ssr_back (
  input  logic                   clk,
  input  logic                   rst,
  input  ssr_pkg::cmd_t          head,
  input  ssr_pkg::queue_status_t qstat,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_byte,
  output logic                   byte_valid,
  output logic                   out_last,
  output logic [31:0]            out_length,
  output logic [31:0]            match_count
);

  logic [2:0]  idx;
  logic [31:0] bytes_emitted;
  logic [31:0] emitted_next;
  logic        advance;
  logic        is_final;
  logic        bvalid;
  logic [7:0]  cur_byte;

  always_comb begin
    advance  = !qstat.empty && (!out_valid || out_ready);
    bvalid   = (head.count != 4'd0);
    is_final = !bvalid || ({1'b0, idx} == head.count - 4'd1);
    cur_byte = bvalid ? head.data[{idx, 3'b000} +: 8] : 8'd0;
    emitted_next = bvalid ? ssr_pkg::sat_inc(bytes_emitted) : bytes_emitted;
    pop = advance && is_final;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx           <= 3'd0;
      bytes_emitted <= 32'd0;
      out_valid     <= 1'b0;
    end else if (advance) begin
      idx           <= is_final ? 3'd0 : idx + 3'd1;
      bytes_emitted <= (head.last && is_final) ? 32'd0 : emitted_next;
      out_valid     <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte    <= cur_byte;
      byte_valid  <= bvalid;
      out_last    <= head.last && is_final;
      out_length  <= emitted_next;
      match_count <= head.match_cnt;
    end
  end

endmodule
